// File: sv/vpa_pkg.sv
package vpa_pkg;

  localparam int IDX_W   = 6;
  localparam int COUNT_W = 7;
  localparam logic [31:0] POOL_SIZE_RESET = 32'd1024;
  localparam logic [7:0]  SPLIT_MIN_RESET = 8'd48;

  typedef enum logic [2:0] {
    FUNC_ALLOC   = 3'd0,
    FUNC_REALLOC = 3'd1,
    FUNC_FREE    = 3'd2,
    FUNC_DUMP    = 3'd3,
    FUNC_INIT    = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_BAD_FUNC  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NONE  = 2'd3
  } fit_t;

  typedef enum logic [1:0] {
    CFG_FIT       = 2'd0,
    CFG_POOL_SIZE = 2'd1,
    CFG_SPLIT_MIN = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_INSERT,
    OP_REMOVE,
    OP_INIT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIT_SCAN,
    S_ALLOC_APPLY,
    S_ALLOC_MARK,
    S_OWN_SCAN,
    S_RE_DECIDE,
    S_SHRINK_INS,
    S_GROW_CHECK,
    S_GROW_WRITE,
    S_GROW_INS,
    S_FREE_FWD,
    S_FREE_BWD,
    S_EMIT,
    S_DUMP
  } ctrl_state_t;

  typedef struct packed {
    logic [31:0] off;
    logic [31:0] size;
    logic        free;
    logic [15:0] owner;
  } seg_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] ridx;
    seg_t             seg;
  } dp_cmd_t;

  typedef struct packed {
    seg_t               rd;
    logic [COUNT_W-1:0] count;
  } dp_stat_t;

  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [IDX_W-1:0] idx;
    logic             use_entry;
    logic             last;
  } emit_t;

endpackage

// File: sv/vpa_dp.sv
module vpa_dp #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  vpa_pkg::dp_cmd_t  cmd,
  output vpa_pkg::dp_stat_t stat
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  logic [31:0] offs   [MAX_SEGMENTS];
  logic [31:0] sizes  [MAX_SEGMENTS];
  logic        frees  [MAX_SEGMENTS];
  logic [15:0] owners [MAX_SEGMENTS];
  logic [vpa_pkg::COUNT_W-1:0] count;

  logic [IW-1:0] widx;
  logic [IW-1:0] ridx;

  assign widx = cmd.idx[IW-1:0];
  assign ridx = cmd.ridx[IW-1:0];

  always_comb begin
    stat.rd.off   = offs[ridx];
    stat.rd.size  = sizes[ridx];
    stat.rd.free  = frees[ridx];
    stat.rd.owner = owners[ridx];
    stat.count    = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= vpa_pkg::COUNT_W'(1);
      offs[0]  <= '0;
      sizes[0] <= vpa_pkg::POOL_SIZE_RESET;
      frees[0] <= 1'b1;
    end else begin
      unique case (cmd.op)
        vpa_pkg::OP_WRITE: begin
          offs[widx]  <= cmd.seg.off;
          sizes[widx] <= cmd.seg.size;
          frees[widx] <= cmd.seg.free;
        end
        vpa_pkg::OP_INSERT: begin
          for (int i = 1; i < MAX_SEGMENTS; i++) begin
            if (IW'(i) > widx) begin
              offs[i]  <= offs[i-1];
              sizes[i] <= sizes[i-1];
              frees[i] <= frees[i-1];
            end
          end
          offs[widx]  <= cmd.seg.off;
          sizes[widx] <= cmd.seg.size;
          frees[widx] <= 1'b1;
          count       <= count + vpa_pkg::COUNT_W'(1);
        end
        vpa_pkg::OP_REMOVE: begin
          for (int i = 0; i < MAX_SEGMENTS - 1; i++) begin
            if (IW'(i) >= widx) begin
              offs[i]  <= offs[i+1];
              sizes[i] <= sizes[i+1];
              frees[i] <= frees[i+1];
            end
          end
          count <= count - vpa_pkg::COUNT_W'(1);
        end
        vpa_pkg::OP_INIT: begin
          count    <= vpa_pkg::COUNT_W'(1);
          offs[0]  <= '0;
          sizes[0] <= cmd.seg.size;
          frees[0] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // owners reset undefined: only busy entries are ever read
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      vpa_pkg::OP_WRITE: owners[widx] <= cmd.seg.owner;
      vpa_pkg::OP_INSERT: begin
        for (int i = 1; i < MAX_SEGMENTS; i++) begin
          if (IW'(i) > widx) owners[i] <= owners[i-1];
        end
        owners[widx] <= '0;
      end
      vpa_pkg::OP_REMOVE: begin
        for (int i = 0; i < MAX_SEGMENTS - 1; i++) begin
          if (IW'(i) >= widx) owners[i] <= owners[i+1];
        end
      end
      default: ;
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count <= vpa_pkg::COUNT_W'(MAX_SEGMENTS))
    else $error("segment count out of range");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.op == vpa_pkg::OP_INSERT |->
      count < vpa_pkg::COUNT_W'(MAX_SEGMENTS) && {1'b0, cmd.idx} <= count)
    else $error("insert into full table");

  a_remove_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == vpa_pkg::OP_REMOVE |-> count > vpa_pkg::COUNT_W'(1) && {1'b0, cmd.idx} < count)
    else $error("remove outside table");

  a_write_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == vpa_pkg::OP_WRITE |-> {1'b0, cmd.idx} < count)
    else $error("write outside table");

endmodule

// File: sv/vpa_ctrl.sv
module vpa_ctrl #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_func,
  input  logic [15:0]       in_owner,
  input  logic [31:0]       in_req,
  input  logic [1:0]        fit_strategy,
  input  logic [31:0]       pool_size,
  input  logic [7:0]        split_min,
  input  vpa_pkg::dp_stat_t stat,
  output vpa_pkg::dp_cmd_t  cmd,
  output vpa_pkg::emit_t    emit,
  input  logic              out_ready
);

  localparam int CW = vpa_pkg::COUNT_W;
  localparam int XW = vpa_pkg::IDX_W;

  vpa_pkg::ctrl_state_t state, state_next;

  logic [2:0]    func;
  logic [15:0]   owner;
  logic [31:0]   req;
  logic [CW-1:0] i;
  logic          found;
  logic [XW-1:0] pick;
  logic [31:0]   pick_off;
  logic [31:0]   pick_size;
  logic [31:0]   size_w;
  logic [XW-1:0] b;
  logic [31:0]   cur;
  logic [31:0]   boff;
  logic [31:0]   acc;
  vpa_pkg::status_t st;
  logic [XW-1:0] emit_idx;

  vpa_pkg::seg_t rd;
  logic [CW-1:0] count;
  logic          in_range, fit_hit, fit_better, own_hit;
  logic [CW-1:0] b1;
  logic          b1_in, grow_ok, fwd_ok, bwd_ok;
  logic [32:0]   grow_sum;
  logic [31:0]   alloc_rest, shrink_rest, grow_rest;
  logic          split_alloc, split_shrink, table_full, dump_last;

  assign rd           = stat.rd;
  assign count        = stat.count;
  assign in_range     = i < count;
  assign fit_hit      = rd.free && rd.size >= req;
  assign fit_better   = !found ||
                        (fit_strategy == vpa_pkg::FIT_BEST && rd.size < pick_size) ||
                        (fit_strategy == vpa_pkg::FIT_WORST && rd.size > pick_size);
  assign own_hit      = !rd.free && rd.owner == owner;
  assign b1           = {1'b0, b} + CW'(1);
  assign b1_in        = b1 < count;
  assign grow_sum     = {1'b0, cur} + {1'b0, rd.size};
  assign grow_ok      = b1_in && rd.free && grow_sum >= {1'b0, req};
  assign fwd_ok       = b1_in && rd.free;
  assign bwd_ok       = b != '0 && rd.free;
  assign alloc_rest   = pick_size - req;
  assign shrink_rest  = cur - req;
  assign grow_rest    = acc - req;
  assign split_alloc  = alloc_rest > {24'd0, split_min};
  assign split_shrink = shrink_rest >= {24'd0, split_min};
  assign table_full   = count >= CW'(MAX_SEGMENTS);
  assign dump_last    = (i + CW'(1)) == count;

  assign in_ready = state == vpa_pkg::S_IDLE;

  always_comb begin
    state_next = state;
    unique case (state)
      vpa_pkg::S_IDLE: if (in_valid) state_next = vpa_pkg::S_DISPATCH;
      vpa_pkg::S_DISPATCH: begin
        unique case (func)
          vpa_pkg::FUNC_ALLOC:
            state_next = (req == '0 || fit_strategy == vpa_pkg::FIT_NONE) ?
                         vpa_pkg::S_EMIT : vpa_pkg::S_FIT_SCAN;
          vpa_pkg::FUNC_REALLOC, vpa_pkg::FUNC_FREE: state_next = vpa_pkg::S_OWN_SCAN;
          vpa_pkg::FUNC_DUMP: state_next = vpa_pkg::S_DUMP;
          default: state_next = vpa_pkg::S_EMIT;
        endcase
      end
      vpa_pkg::S_FIT_SCAN: begin
        if (!in_range) begin
          state_next = found ? vpa_pkg::S_ALLOC_APPLY : vpa_pkg::S_EMIT;
        end else if (fit_hit && fit_strategy == vpa_pkg::FIT_FIRST) begin
          state_next = vpa_pkg::S_ALLOC_APPLY;
        end
      end
      vpa_pkg::S_ALLOC_APPLY:
        state_next = (split_alloc && table_full) ? vpa_pkg::S_EMIT : vpa_pkg::S_ALLOC_MARK;
      vpa_pkg::S_ALLOC_MARK: state_next = vpa_pkg::S_EMIT;
      vpa_pkg::S_OWN_SCAN: begin
        if (!in_range) begin
          state_next = vpa_pkg::S_EMIT;
        end else if (own_hit) begin
          state_next = (func == vpa_pkg::FUNC_FREE) ? vpa_pkg::S_FREE_FWD : vpa_pkg::S_RE_DECIDE;
        end
      end
      vpa_pkg::S_RE_DECIDE: begin
        priority if (req == cur) state_next = vpa_pkg::S_EMIT;
        else if (req > cur) state_next = vpa_pkg::S_GROW_CHECK;
        else if (split_shrink && !table_full) state_next = vpa_pkg::S_SHRINK_INS;
        else state_next = vpa_pkg::S_EMIT;
      end
      vpa_pkg::S_SHRINK_INS: state_next = vpa_pkg::S_EMIT;
      vpa_pkg::S_GROW_CHECK: begin
        priority if (grow_ok) state_next = vpa_pkg::S_GROW_WRITE;
        else if (fit_strategy == vpa_pkg::FIT_NONE) state_next = vpa_pkg::S_EMIT;
        else state_next = vpa_pkg::S_FIT_SCAN;
      end
      vpa_pkg::S_GROW_WRITE:
        state_next = (acc != req) ? vpa_pkg::S_GROW_INS : vpa_pkg::S_EMIT;
      vpa_pkg::S_GROW_INS: state_next = vpa_pkg::S_EMIT;
      vpa_pkg::S_FREE_FWD: if (!fwd_ok) state_next = vpa_pkg::S_FREE_BWD;
      vpa_pkg::S_FREE_BWD: if (!bwd_ok) state_next = vpa_pkg::S_EMIT;
      vpa_pkg::S_EMIT: if (out_ready) state_next = vpa_pkg::S_IDLE;
      vpa_pkg::S_DUMP: if (out_ready && dump_last) state_next = vpa_pkg::S_IDLE;
      default: state_next = vpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.op         = vpa_pkg::OP_NONE;
    emit           = '0;
    emit.status    = vpa_pkg::ST_OK;
    unique case (state)
      vpa_pkg::S_DISPATCH: begin
        if (func == vpa_pkg::FUNC_INIT) begin
          cmd.op       = vpa_pkg::OP_INIT;
          cmd.seg.size = pool_size;
        end
      end
      vpa_pkg::S_FIT_SCAN, vpa_pkg::S_OWN_SCAN: cmd.ridx = i[XW-1:0];
      vpa_pkg::S_ALLOC_APPLY: begin
        if (split_alloc && !table_full) begin
          cmd.op       = vpa_pkg::OP_INSERT;
          cmd.idx      = pick + XW'(1);
          cmd.seg.off  = pick_off + req;
          cmd.seg.size = alloc_rest;
          cmd.seg.free = 1'b1;
        end
      end
      vpa_pkg::S_ALLOC_MARK: begin
        cmd.op        = vpa_pkg::OP_WRITE;
        cmd.idx       = pick;
        cmd.seg.off   = pick_off;
        cmd.seg.size  = size_w;
        cmd.seg.owner = owner;
      end
      vpa_pkg::S_RE_DECIDE: begin
        if (req < cur && split_shrink) begin
          cmd.op        = vpa_pkg::OP_WRITE;
          cmd.idx       = b;
          cmd.seg.off   = boff;
          cmd.seg.size  = req;
          cmd.seg.owner = owner;
        end
      end
      vpa_pkg::S_SHRINK_INS: begin
        cmd.op       = vpa_pkg::OP_INSERT;
        cmd.idx      = b1[XW-1:0];
        cmd.seg.off  = boff + req;
        cmd.seg.size = shrink_rest;
        cmd.seg.free = 1'b1;
      end
      vpa_pkg::S_GROW_CHECK: begin
        cmd.ridx = b1[XW-1:0];
        if (grow_ok) begin
          cmd.op  = vpa_pkg::OP_REMOVE;
          cmd.idx = b1[XW-1:0];
        end
      end
      vpa_pkg::S_GROW_WRITE: begin
        cmd.op        = vpa_pkg::OP_WRITE;
        cmd.idx       = b;
        cmd.seg.off   = boff;
        cmd.seg.size  = req;
        cmd.seg.owner = owner;
      end
      vpa_pkg::S_GROW_INS: begin
        cmd.op       = vpa_pkg::OP_INSERT;
        cmd.idx      = b1[XW-1:0];
        cmd.seg.off  = boff + req;
        cmd.seg.size = grow_rest;
        cmd.seg.free = 1'b1;
      end
      vpa_pkg::S_FREE_FWD: begin
        cmd.ridx = b1[XW-1:0];
        if (fwd_ok) begin
          cmd.op  = vpa_pkg::OP_REMOVE;
          cmd.idx = b1[XW-1:0];
        end
      end
      vpa_pkg::S_FREE_BWD: begin
        cmd.ridx = b - XW'(1);
        cmd.idx  = b;
        if (bwd_ok) begin
          cmd.op = vpa_pkg::OP_REMOVE;
        end else begin
          cmd.op       = vpa_pkg::OP_WRITE;
          cmd.seg.off  = boff;
          cmd.seg.size = acc;
          cmd.seg.free = 1'b1;
        end
      end
      vpa_pkg::S_EMIT: begin
        cmd.ridx       = emit_idx;
        emit.valid     = 1'b1;
        emit.status    = st;
        emit.idx       = emit_idx;
        emit.use_entry = st == vpa_pkg::ST_OK;
        emit.last      = 1'b1;
      end
      vpa_pkg::S_DUMP: begin
        cmd.ridx       = i[XW-1:0];
        emit.valid     = 1'b1;
        emit.idx       = i[XW-1:0];
        emit.use_entry = 1'b1;
        emit.last      = dump_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= vpa_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      vpa_pkg::S_IDLE: begin
        if (in_valid) begin
          func  <= in_func;
          owner <= in_owner;
          req   <= in_req;
        end
      end
      vpa_pkg::S_DISPATCH: begin
        i     <= '0;
        found <= 1'b0;
        unique case (func)
          vpa_pkg::FUNC_ALLOC: begin
            if (req == '0) st <= vpa_pkg::ST_ZERO_SIZE;
            else if (fit_strategy == vpa_pkg::FIT_NONE) st <= vpa_pkg::ST_NO_FIT;
          end
          vpa_pkg::FUNC_REALLOC, vpa_pkg::FUNC_FREE, vpa_pkg::FUNC_DUMP: ;
          vpa_pkg::FUNC_INIT: begin
            emit_idx <= '0;
            st       <= vpa_pkg::ST_OK;
          end
          default: st <= vpa_pkg::ST_BAD_FUNC;
        endcase
      end
      vpa_pkg::S_FIT_SCAN: begin
        if (!in_range) begin
          if (!found) st <= vpa_pkg::ST_NO_FIT;
        end else if (fit_hit && (fit_strategy == vpa_pkg::FIT_FIRST || fit_better)) begin
          pick      <= i[XW-1:0];
          pick_off  <= rd.off;
          pick_size <= rd.size;
          found     <= 1'b1;
        end
        i <= i + CW'(1);
      end
      vpa_pkg::S_ALLOC_APPLY: begin
        if (split_alloc) begin
          if (table_full) st <= vpa_pkg::ST_FULL;
          size_w <= req;
        end else begin
          size_w <= pick_size;
        end
      end
      vpa_pkg::S_ALLOC_MARK: begin
        emit_idx <= pick;
        st       <= vpa_pkg::ST_OK;
      end
      vpa_pkg::S_OWN_SCAN: begin
        if (!in_range) begin
          st <= vpa_pkg::ST_NOT_FOUND;
        end else if (own_hit) begin
          b    <= i[XW-1:0];
          cur  <= rd.size;
          boff <= rd.off;
          acc  <= rd.size;
        end
        i <= i + CW'(1);
      end
      vpa_pkg::S_RE_DECIDE: begin
        emit_idx <= b;
        st       <= vpa_pkg::ST_OK;
        i        <= '0;
        found    <= 1'b0;
      end
      vpa_pkg::S_GROW_CHECK: begin
        if (grow_ok) acc <= grow_sum[31:0];
        else if (fit_strategy == vpa_pkg::FIT_NONE) st <= vpa_pkg::ST_NO_FIT;
      end
      vpa_pkg::S_FREE_FWD: begin
        if (fwd_ok) acc <= acc + rd.size;
      end
      vpa_pkg::S_FREE_BWD: begin
        if (bwd_ok) begin
          // fold into the lower neighbor and move down to it
          acc  <= acc + rd.size;
          boff <= rd.off;
          b    <= b - XW'(1);
        end else begin
          emit_idx <= b;
          st       <= vpa_pkg::ST_OK;
        end
      end
      vpa_pkg::S_DUMP: begin
        if (out_ready && !dump_last) i <= i + CW'(1);
      end
      default: ;
    endcase
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == vpa_pkg::S_DISPATCH)
    else $error("accepted word not dispatched");

  a_emit_ok_entry: assert property (@(posedge clk) disable iff (rst)
    emit.valid && emit.use_entry |-> {1'b0, emit.idx} < count)
    else $error("reported segment outside table");

  a_no_cmd_while_emit: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> cmd.op == vpa_pkg::OP_NONE)
    else $error("table changed while reporting");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    emit.valid && emit.last && out_ready |=> state == vpa_pkg::S_IDLE)
    else $error("command did not finish after last word");

endmodule

// File: sv/variable_partition_allocator.sv
// Segment allocator over a pool: an address-ordered table of up to MAX_SEGMENTS
// segments, one command per input word (alloc, realloc, free, dump, init).
// Commands run one at a time through a sequencer that reads one table entry per
// cycle (a dump holds while the output stalls); splits and merges shift the
// entries above the split or merge point in one table command. An alloc scans
// the table for a fit, a free merges with free neighbors on both sides, a realloc
// shrinks or grows in place or falls back to a fresh allocation when a grow fails,
// and a dump reports every entry; an output stall holds any command. Results leave
// through an output register; no clearing pass is needed after reset.
module variable_partition_allocator #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // func[2:0], owner_id[18:3], request_size[50:19]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // seg_index[5:0], seg_offset[37:6], seg_length[69:38],
                                 // seg_is_free[70], seg_owner[86:71]
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [1:0]  fit_strategy;
  logic [31:0] pool_size;
  logic [7:0]  split_min;

  vpa_pkg::dp_cmd_t  cmd;
  vpa_pkg::dp_stat_t stat;
  vpa_pkg::emit_t    emit;
  logic              out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_strategy <= vpa_pkg::FIT_FIRST;
      pool_size    <= vpa_pkg::POOL_SIZE_RESET;
      split_min    <= vpa_pkg::SPLIT_MIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vpa_pkg::CFG_FIT:       fit_strategy <= cfg_data[1:0];
        vpa_pkg::CFG_POOL_SIZE: pool_size    <= cfg_data;
        vpa_pkg::CFG_SPLIT_MIN: split_min    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  vpa_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_func      (s_tdata[2:0]),
    .in_owner     (s_tdata[18:3]),
    .in_req       (s_tdata[50:19]),
    .fit_strategy (fit_strategy),
    .pool_size    (pool_size),
    .split_min    (split_min),
    .stat         (stat),
    .cmd          (cmd),
    .emit         (emit),
    .out_ready    (out_ready)
  );

  vpa_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  assign out_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_ready) m_tvalid <= emit.valid;
  end

  // load a result word; error words carry no segment
  always_ff @(posedge clk) begin
    if (out_ready && emit.valid) begin
      m_tuser <= emit.status;
      m_tlast <= emit.last;
      m_tdata[87] <= 1'b0;
      if (emit.use_entry) begin
        m_tdata[5:0]   <= emit.idx;
        m_tdata[37:6]  <= stat.rd.off;
        m_tdata[69:38] <= stat.rd.size;
        m_tdata[70]    <= stat.rd.free;
        m_tdata[86:71] <= stat.rd.free ? 16'd0 : stat.rd.owner;
      end else begin
        m_tdata[86:0] <= '0;
      end
    end
  end

endmodule
